[design/mcr_pkg.sv]
// Shared types and constants for the midpoint circle rasterizer.
// No dependencies; every other design file refers to it by scoped names.
package mcr_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_SCREEN_DIM_DEF   = 4096;
    localparam int OFFSET_FRAC_BITS_DEF = 4;

    // Fixed field widths
    localparam int COORD_W   = 16;
    localparam int RADIUS_W  = 12;
    localparam int COLOR_W   = 32;
    localparam int STEP_W    = 13;
    localparam int DEC_W     = 16;
    localparam int DIM_W     = 13;
    localparam int SCROLL_W  = 20;
    localparam int PIX_W     = 12;
    localparam int ADDR_W    = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 20;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_X      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_Y      = 2'd3;

    // Configuration reset values
    localparam logic [DIM_W-1:0] SCREEN_WIDTH_RST  = 13'd640;
    localparam logic [DIM_W-1:0] SCREEN_HEIGHT_RST = 13'd480;

    // Item opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [DIM_W-1:0]           screen_width;
        logic [DIM_W-1:0]           screen_height;
        logic signed [SCROLL_W-1:0] scroll_x;
        logic signed [SCROLL_W-1:0] scroll_y;
    } mcr_cfg_t;

    // One job: either a null result or the eight octant points of a step
    typedef struct packed {
        logic                      is_null;
        logic                      done;
        logic                      lock;
        logic [COLOR_W-1:0]        color;
        logic signed [COORD_W-1:0] ctr_x;
        logic signed [COORD_W-1:0] ctr_y;
        logic signed [STEP_W-1:0]  step_u;
        logic signed [STEP_W-1:0]  step_v;
    } mcr_job_t;

endpackage

[design/midpoint_circle_rasterizer_unit.sv]
// Top level of the midpoint circle rasterizer: configuration registers,
// front end, job queue and point generator. Depends on mcr_pkg and submodules.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one item per cycle unless
//   stalled: op = start loads a circle, op = step advances it by one octant
//   step. Output channel (out_valid / out_stall) carries one point per cycle
//   unless stalled; last_of_step marks the final result of an item,
//   circle_done tells the sender to stop stepping. A visible start or an
//   active step gives eight results, one per cycle unless the output stalls;
//   the point generator walks the octants through a single placement and
//   address path. A culled start or a step while idle gives one result.
//   An accepted item passes the queue, point select, place and clip, and the
//   address multiply and output register on its way to its first result.
//   The front end runs ahead by up to two queued jobs; in_stall rises when
//   the queue is full. When the receiver stalls, the output register holds
//   and the pipeline fills, then the queue, then in_stall asserts.
//   Configuration writes (cfg_wr_en, cfg_index, cfg_data) take effect at once
//   and are meant for idle periods only.
//   Reset clears the circle state, restores 640x480 with zero scroll, and
//   empties the pipeline.
module midpoint_circle_rasterizer_unit #(
    parameter int MAX_SCREEN_DIM   = mcr_pkg::MAX_SCREEN_DIM_DEF,
    parameter int OFFSET_FRAC_BITS = mcr_pkg::OFFSET_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [mcr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mcr_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                op,
    input  logic signed [mcr_pkg::COORD_W-1:0]  center_x,
    input  logic signed [mcr_pkg::COORD_W-1:0]  center_y,
    input  logic [mcr_pkg::RADIUS_W-1:0]        circle_radius,
    input  logic [mcr_pkg::COLOR_W-1:0]         pen_color,
    input  logic                                lock_to_screen,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [mcr_pkg::PIX_W-1:0]           pixel_x,
    output logic [mcr_pkg::PIX_W-1:0]           pixel_y,
    output logic [mcr_pkg::ADDR_W-1:0]          pixel_addr,
    output logic [mcr_pkg::COLOR_W-1:0]         pixel_color,
    output logic                                write_enable,
    output logic                                last_of_step,
    output logic                                circle_done
);

    mcr_pkg::mcr_cfg_t cfg_reg, cfg_next;
    mcr_pkg::mcr_job_t push_job, head;
    logic              job_push, job_full, pop, head_valid;

    // Decode configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                mcr_pkg::CFG_SCREEN_WIDTH:  cfg_next.screen_width  = cfg_data[mcr_pkg::DIM_W-1:0];
                mcr_pkg::CFG_SCREEN_HEIGHT: cfg_next.screen_height = cfg_data[mcr_pkg::DIM_W-1:0];
                mcr_pkg::CFG_SCROLL_X:      cfg_next.scroll_x      = $signed(cfg_data);
                mcr_pkg::CFG_SCROLL_Y:      cfg_next.scroll_y      = $signed(cfg_data);
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_width  <= mcr_pkg::SCREEN_WIDTH_RST;
            cfg_reg.screen_height <= mcr_pkg::SCREEN_HEIGHT_RST;
            cfg_reg.scroll_x      <= '0;
            cfg_reg.scroll_y      <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    mcr_front #(
        .OFFSET_FRAC_BITS(OFFSET_FRAC_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .center_x       (center_x),
        .center_y       (center_y),
        .circle_radius  (circle_radius),
        .pen_color      (pen_color),
        .lock_to_screen (lock_to_screen),
        .job            (push_job),
        .job_push       (job_push),
        .job_full       (job_full)
    );

    mcr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_push),
        .push_job   (push_job),
        .full       (job_full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    mcr_back #(
        .MAX_SCREEN_DIM  (MAX_SCREEN_DIM),
        .OFFSET_FRAC_BITS(OFFSET_FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head         (head),
        .head_valid   (head_valid),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .pixel_addr   (pixel_addr),
        .pixel_color  (pixel_color),
        .write_enable (write_enable),
        .last_of_step (last_of_step),
        .circle_done  (circle_done)
    );

endmodule

[design/mcr_front.sv]
// Front end: accepts items, runs the cull test and the midpoint step,
// and pushes one job per item into the queue. Depends on mcr_pkg.
module mcr_front #(
    parameter int OFFSET_FRAC_BITS = mcr_pkg::OFFSET_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mcr_pkg::mcr_cfg_t                   cfg,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                op,
    input  logic signed [mcr_pkg::COORD_W-1:0]  center_x,
    input  logic signed [mcr_pkg::COORD_W-1:0]  center_y,
    input  logic [mcr_pkg::RADIUS_W-1:0]        circle_radius,
    input  logic [mcr_pkg::COLOR_W-1:0]         pen_color,
    input  logic                                lock_to_screen,
    output mcr_pkg::mcr_job_t                   job,
    output logic                                job_push,
    input  logic                                job_full
);

    localparam int CW = 22 + OFFSET_FRAC_BITS;

    logic                                active_reg, active_next;
    logic signed [mcr_pkg::COORD_W-1:0]  ctr_x_reg, ctr_x_next;
    logic signed [mcr_pkg::COORD_W-1:0]  ctr_y_reg, ctr_y_next;
    logic signed [mcr_pkg::STEP_W-1:0]   u_reg, u_next;
    logic signed [mcr_pkg::STEP_W-1:0]   v_reg, v_next;
    logic signed [mcr_pkg::DEC_W-1:0]    dec_reg, dec_next;
    logic [mcr_pkg::COLOR_W-1:0]         color_reg, color_next;
    logic                                lock_reg, lock_next;

    logic                                accept;
    logic signed [17:0]                  xp, xm, yp, ym;
    logic signed [CW-1:0]                xp_s, xm_s, yp_s, ym_s;
    logic signed [CW-1:0]                sx_w, sy_w, wlim, hlim;
    logic                                culled;
    logic signed [mcr_pkg::STEP_W-1:0]   u1, v1;
    logic                                dec_pos;
    logic signed [mcr_pkg::DEC_W-1:0]    u1_w, v1_w, dec1, dec_start;
    logic                                step_done;
    mcr_pkg::mcr_job_t                   null_job;

    assign in_stall = job_full;
    assign accept   = in_valid && !job_full;
    assign job_push = accept;

    // Cull bounds: center plus and minus radius, in offset fixed point
    always_comb
    begin
        xp = $signed({{2{center_x[15]}}, center_x}) + $signed({6'b0, circle_radius});
        xm = $signed({{2{center_x[15]}}, center_x}) - $signed({6'b0, circle_radius});
        yp = $signed({{2{center_y[15]}}, center_y}) + $signed({6'b0, circle_radius});
        ym = $signed({{2{center_y[15]}}, center_y}) - $signed({6'b0, circle_radius});
        sx_w = {{(CW-mcr_pkg::SCROLL_W){cfg.scroll_x[mcr_pkg::SCROLL_W-1]}}, cfg.scroll_x};
        sy_w = {{(CW-mcr_pkg::SCROLL_W){cfg.scroll_y[mcr_pkg::SCROLL_W-1]}}, cfg.scroll_y};
        wlim = $signed({{(CW-mcr_pkg::DIM_W){1'b0}}, cfg.screen_width}) <<< OFFSET_FRAC_BITS;
        hlim = $signed({{(CW-mcr_pkg::DIM_W){1'b0}}, cfg.screen_height}) <<< OFFSET_FRAC_BITS;
        xp_s = ($signed({{(CW-18){xp[17]}}, xp}) <<< OFFSET_FRAC_BITS) + sx_w;
        xm_s = ($signed({{(CW-18){xm[17]}}, xm}) <<< OFFSET_FRAC_BITS) + sx_w;
        yp_s = ($signed({{(CW-18){yp[17]}}, yp}) <<< OFFSET_FRAC_BITS) + sy_w;
        ym_s = ($signed({{(CW-18){ym[17]}}, ym}) <<< OFFSET_FRAC_BITS) + sy_w;
        culled = (xp_s < 0) || (xm_s > wlim) || (yp_s < 0) || (ym_s > hlim);
    end

    // Midpoint step: advance u, maybe drop v, update the decision term
    always_comb
    begin
        u1      = u_reg + 13'sd1;
        dec_pos = dec_reg > 16'sd0;
        v1      = dec_pos ? (v_reg - 13'sd1) : v_reg;
        u1_w    = {{(mcr_pkg::DEC_W-mcr_pkg::STEP_W){u1[mcr_pkg::STEP_W-1]}}, u1};
        v1_w    = {{(mcr_pkg::DEC_W-mcr_pkg::STEP_W){v1[mcr_pkg::STEP_W-1]}}, v1};
        if (dec_pos)
        begin
            dec1 = dec_reg + ((u1_w - v1_w) <<< 2) + 16'sd10;
        end
        else
        begin
            dec1 = dec_reg + (u1_w <<< 2) + 16'sd6;
        end
        step_done = v1 < u1;
        dec_start = 16'sd3 - $signed({3'b0, circle_radius, 1'b0});
    end

    // Build the job and the next state
    always_comb
    begin
        null_job         = '0;
        null_job.is_null = 1'b1;
        null_job.done    = 1'b1;

        active_next = active_reg;
        ctr_x_next  = ctr_x_reg;
        ctr_y_next  = ctr_y_reg;
        u_next      = u_reg;
        v_next      = v_reg;
        dec_next    = dec_reg;
        color_next  = color_reg;
        lock_next   = lock_reg;
        job         = null_job;

        if (op == mcr_pkg::OP_START)
        begin
            if (culled)
            begin
                active_next = 1'b0;
            end
            else
            begin
                active_next = 1'b1;
                ctr_x_next  = center_x;
                ctr_y_next  = center_y;
                u_next      = '0;
                v_next      = $signed({1'b0, circle_radius});
                dec_next    = dec_start;
                color_next  = pen_color;
                lock_next   = lock_to_screen;
                job.is_null = 1'b0;
                job.done    = 1'b0;
                job.lock    = lock_to_screen;
                job.color   = pen_color;
                job.ctr_x   = center_x;
                job.ctr_y   = center_y;
                job.step_u  = '0;
                job.step_v  = $signed({1'b0, circle_radius});
            end
        end
        else if (active_reg)
        begin
            active_next = !step_done;
            u_next      = u1;
            v_next      = v1;
            dec_next    = dec1;
            job.is_null = 1'b0;
            job.done    = step_done;
            job.lock    = lock_reg;
            job.color   = color_reg;
            job.ctr_x   = ctr_x_reg;
            job.ctr_y   = ctr_y_reg;
            job.step_u  = u1;
            job.step_v  = v1;
        end
    end

    // Hold circle state; update on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            ctr_x_reg  <= '0;
            ctr_y_reg  <= '0;
            u_reg      <= '0;
            v_reg      <= '0;
            dec_reg    <= '0;
            color_reg  <= '0;
            lock_reg   <= 1'b0;
        end
        else if (accept)
        begin
            active_reg <= active_next;
            ctr_x_reg  <= ctr_x_next;
            ctr_y_reg  <= ctr_y_next;
            u_reg      <= u_next;
            v_reg      <= v_next;
            dec_reg    <= dec_next;
            color_reg  <= color_next;
            lock_reg   <= lock_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && op == mcr_pkg::OP_STEP && active_reg && step_done |=> !active_reg)
        else $error("circle still active after its final step");

    a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
        accept && op == mcr_pkg::OP_START && !culled |=> active_reg && u_reg == 13'sd0)
        else $error("visible start did not load the circle");
`endif

endmodule

[design/mcr_queue.sv]
// Short job queue between the front end and the point generator.
// Depends on mcr_pkg for the job type and depth.
module mcr_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mcr_pkg::mcr_job_t push_job,
    output logic              full,
    input  logic              pop,
    output mcr_pkg::mcr_job_t head,
    output logic              head_valid
);

    localparam int QAW = (mcr_pkg::QUEUE_DEPTH > 1) ? $clog2(mcr_pkg::QUEUE_DEPTH) : 1;

    mcr_pkg::mcr_job_t mem_reg [mcr_pkg::QUEUE_DEPTH];
    logic [QAW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]      count_reg, count_next;

    assign full       = count_reg == (QAW+1)'(mcr_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = mem_reg[rd_ptr_reg];

    // Advance pointers with wrap and track the fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(mcr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(mcr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + (QAW+1)'(push) - (QAW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed job
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QAW+1)'(mcr_pkg::QUEUE_DEPTH))
        else $error("job queue overfilled");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("job popped from empty queue");
`endif

endmodule

[design/mcr_back.sv]
// Point generator: walks the eight octant points of a non-null job, applies the
// scroll offset, clips, and forms the framebuffer address. Depends on mcr_pkg.
module mcr_back #(
    parameter int MAX_SCREEN_DIM   = mcr_pkg::MAX_SCREEN_DIM_DEF,
    parameter int OFFSET_FRAC_BITS = mcr_pkg::OFFSET_FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mcr_pkg::mcr_cfg_t            cfg,
    input  mcr_pkg::mcr_job_t            head,
    input  logic                         head_valid,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [mcr_pkg::PIX_W-1:0]    pixel_x,
    output logic [mcr_pkg::PIX_W-1:0]    pixel_y,
    output logic [mcr_pkg::ADDR_W-1:0]   pixel_addr,
    output logic [mcr_pkg::COLOR_W-1:0]  pixel_color,
    output logic                         write_enable,
    output logic                         last_of_step,
    output logic                         circle_done
);

    localparam int DW = $clog2(MAX_SCREEN_DIM + 1);
    localparam int PW = 21 + OFFSET_FRAC_BITS;
    localparam logic signed [PW-1:0] BIAS = PW'((64'sd1 <<< OFFSET_FRAC_BITS) - 64'sd1);

    // Point counter within the current job
    logic [2:0]                   k_reg, k_next;

    // Stage P: selected point
    logic                         p_valid_reg;
    logic signed [17:0]           p_x_reg, p_y_reg;
    logic                         p_lock_reg, p_null_reg, p_last_reg, p_done_reg;
    logic [mcr_pkg::COLOR_W-1:0]  p_color_reg;

    // Stage C: placed and clipped point
    logic                         c_valid_reg;
    logic [DW-1:0]                c_x_reg, c_y_reg;
    logic                         c_on_reg, c_last_reg, c_done_reg;
    logic [mcr_pkg::COLOR_W-1:0]  c_color_reg;

    // Stage O: output register
    logic                         o_valid_reg;
    logic [mcr_pkg::PIX_W-1:0]    o_x_reg, o_y_reg;
    logic [mcr_pkg::ADDR_W-1:0]   o_addr_reg;
    logic [mcr_pkg::COLOR_W-1:0]  o_color_reg;
    logic                         o_on_reg, o_last_reg, o_done_reg;

    logic                         o_ready, c_ready, p_ready, take;
    logic [DW-1:0]                w_eff, h_eff;
    logic signed [mcr_pkg::STEP_W-1:0] sel_a, sel_b;
    logic signed [17:0]           a_w, b_w, px, py;
    logic signed [PW-1:0]         x_pl, y_pl, w_cmp, h_cmp;
    logic                         on;
    logic [2*DW-1:0]              prod;
    logic [2*DW:0]                addr_full;

    // Offset, truncate toward zero; locked points pass unchanged
    function automatic logic signed [PW-1:0] place(
        input logic signed [17:0]                 p,
        input logic signed [mcr_pkg::SCROLL_W-1:0] off,
        input logic                               lock
    );
        logic signed [PW-1:0] pe;
        logic signed [PW-1:0] s;
        pe = {{(PW-18){p[17]}}, p};
        s  = (pe <<< OFFSET_FRAC_BITS)
             + {{(PW-mcr_pkg::SCROLL_W){off[mcr_pkg::SCROLL_W-1]}}, off};
        if (s < 0)
        begin
            s = s + BIAS;
        end
        return lock ? pe : (s >>> OFFSET_FRAC_BITS);
    endfunction

    // Clamp screen dimensions to the supported maximum
    assign w_eff = ({19'b0, cfg.screen_width} > 32'(MAX_SCREEN_DIM))
                   ? DW'(MAX_SCREEN_DIM) : DW'(cfg.screen_width);
    assign h_eff = ({19'b0, cfg.screen_height} > 32'(MAX_SCREEN_DIM))
                   ? DW'(MAX_SCREEN_DIM) : DW'(cfg.screen_height);

    // Ready chain from the output back to the queue
    assign o_ready = !o_valid_reg || !out_stall;
    assign c_ready = !c_valid_reg || o_ready;
    assign p_ready = !p_valid_reg || c_ready;
    assign take    = head_valid && p_ready;
    assign pop     = take && (head.is_null || k_reg == 3'd7);

    // Select octant point: bit 2 swaps u and v, bits 0 and 1 negate
    always_comb
    begin
        sel_a = k_reg[2] ? head.step_v : head.step_u;
        sel_b = k_reg[2] ? head.step_u : head.step_v;
        a_w   = {{(18-mcr_pkg::STEP_W){sel_a[mcr_pkg::STEP_W-1]}}, sel_a};
        b_w   = {{(18-mcr_pkg::STEP_W){sel_b[mcr_pkg::STEP_W-1]}}, sel_b};
        px    = {{2{head.ctr_x[15]}}, head.ctr_x} + (k_reg[0] ? -a_w : a_w);
        py    = {{2{head.ctr_y[15]}}, head.ctr_y} + (k_reg[1] ? -b_w : b_w);
        k_next = k_reg;
        if (take)
        begin
            k_next = pop ? 3'd0 : k_reg + 3'd1;
        end
    end

    // Place and clip the point held in stage P
    always_comb
    begin
        x_pl  = place(p_x_reg, cfg.scroll_x, p_lock_reg);
        y_pl  = place(p_y_reg, cfg.scroll_y, p_lock_reg);
        w_cmp = $signed({{(PW-DW){1'b0}}, w_eff});
        h_cmp = $signed({{(PW-DW){1'b0}}, h_eff});
        on    = !p_null_reg && (x_pl >= 0) && (x_pl < w_cmp) && (y_pl >= 0) && (y_pl < h_cmp);
    end

    // Address: column plus row times width
    assign prod      = c_y_reg * w_eff;
    assign addr_full = {1'b0, prod} + {{(DW+1){1'b0}}, c_x_reg};

    // Pipeline valid bits and counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg       <= '0;
            p_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg <= k_next;
            if (p_ready)
            begin
                p_valid_reg <= head_valid;
            end
            if (c_ready)
            begin
                c_valid_reg <= p_valid_reg;
            end
            if (o_ready)
            begin
                o_valid_reg <= c_valid_reg;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            p_x_reg     <= px;
            p_y_reg     <= py;
            p_lock_reg  <= head.lock;
            p_null_reg  <= head.is_null;
            p_last_reg  <= head.is_null || k_reg == 3'd7;
            p_done_reg  <= head.done;
            p_color_reg <= head.color;
        end
        if (c_ready && p_valid_reg)
        begin
            c_x_reg     <= on ? x_pl[DW-1:0] : '0;
            c_y_reg     <= on ? y_pl[DW-1:0] : '0;
            c_on_reg    <= on;
            c_last_reg  <= p_last_reg;
            c_done_reg  <= p_done_reg;
            c_color_reg <= p_color_reg;
        end
        if (o_ready && c_valid_reg)
        begin
            o_x_reg     <= mcr_pkg::PIX_W'(c_x_reg);
            o_y_reg     <= mcr_pkg::PIX_W'(c_y_reg);
            o_addr_reg  <= c_on_reg ? mcr_pkg::ADDR_W'(addr_full) : '0;
            o_on_reg    <= c_on_reg;
            o_last_reg  <= c_last_reg;
            o_done_reg  <= c_done_reg;
            o_color_reg <= c_color_reg;
        end
    end

    assign out_valid    = o_valid_reg;
    assign pixel_x      = o_x_reg;
    assign pixel_y      = o_y_reg;
    assign pixel_addr   = o_addr_reg;
    assign pixel_color  = o_color_reg;
    assign write_enable = o_on_reg;
    assign last_of_step = o_last_reg;
    assign circle_done  = o_done_reg;

`ifndef NO_ASSERTIONS
    a_clip_inside: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg && c_on_reg |-> (c_x_reg < w_eff) && (c_y_reg < h_eff))
        else $error("visible point outside the clip window");

    a_count_on_octant_job: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg != 3'd0 |-> head_valid && !head.is_null)
        else $error("point counter running without an octant job");
`endif

endmodule

[tb/pixel_scoreboard_pkg.sv]
`timescale 1ns / 1ps
// Item and pixel types plus the scoreboard class for the circle rasterizer bench.
// Depends on mcr_pkg for field widths, opcodes, register indexes and reset values.
package pixel_scoreboard_pkg;
    import mcr_pkg::*;

    localparam longint FRAC_SCALE  = longint'(1) << OFFSET_FRAC_BITS_DEF;

    typedef struct packed {
        logic                      op;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [RADIUS_W-1:0]       radius;
        logic [COLOR_W-1:0]        color;
        logic                      lock;
    } circle_item_t;

    typedef struct packed {
        logic [PIX_W-1:0]   x;
        logic [PIX_W-1:0]   y;
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] color;
        logic               we;
        logic               last;
        logic               done;
    } pixel_write_t;

    class pixel_scoreboard;
        // Register copies
        logic [DIM_W-1:0]           width_reg;
        logic [DIM_W-1:0]           height_reg;
        logic signed [SCROLL_W-1:0] scroll_x_reg;
        logic signed [SCROLL_W-1:0] scroll_y_reg;

        // Circle walk state
        logic                       running;
        logic signed [COORD_W-1:0]  ctr_x;
        logic signed [COORD_W-1:0]  ctr_y;
        logic signed [STEP_W-1:0]   step_u;
        logic signed [STEP_W-1:0]   step_v;
        logic signed [DEC_W-1:0]    dterm;
        logic [COLOR_W-1:0]         held_color;
        logic                       held_lock;

        pixel_write_t pending_pixels[$];

        int unsigned errors;
        int unsigned checked;
        int unsigned on_screen;
        int unsigned starts;
        int unsigned steps;
        int unsigned culled;
        int unsigned idle_steps;
        int unsigned finished;

        function new();
            width_reg    = SCREEN_WIDTH_RST;
            height_reg   = SCREEN_HEIGHT_RST;
            scroll_x_reg = '0;
            scroll_y_reg = '0;
            running      = 1'b0;
            ctr_x        = '0;
            ctr_y        = '0;
            step_u       = '0;
            step_v       = '0;
            dterm        = '0;
            held_color   = '0;
            held_lock    = 1'b0;
            errors       = 0;
            checked      = 0;
            on_screen    = 0;
            starts       = 0;
            steps        = 0;
            culled       = 0;
            idle_steps   = 0;
            finished     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SCREEN_WIDTH:  width_reg    = data[DIM_W-1:0];
                CFG_SCREEN_HEIGHT: height_reg   = data[DIM_W-1:0];
                CFG_SCROLL_X:      scroll_x_reg = data;
                CFG_SCROLL_Y:      scroll_y_reg = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction

        // Dimensions above the supported maximum act as the maximum
        function longint clamp_dim(logic [DIM_W-1:0] dim);
            return (dim > MAX_SCREEN_DIM_DEF) ? longint'(MAX_SCREEN_DIM_DEF) : longint'(dim);
        endfunction

        // Apply the scroll offset unless locked, truncating toward zero
        function longint place(longint p, logic signed [SCROLL_W-1:0] off);
            if (held_lock)
                return p;
            return (p * FRAC_SCALE + longint'(off)) / FRAC_SCALE;
        endfunction

        function void push_null();
            pixel_write_t w;
            w      = '0;
            w.last = 1'b1;
            w.done = 1'b1;
            pending_pixels.push_back(w);
        endfunction

        // Queue the eight mirrored points of the current octant position
        function void push_octants(logic done);
            longint cx;
            longint cy;
            longint u;
            longint v;
            longint xs;
            longint ys;
            longint wd;
            longint ht;
            longint a;
            longint px[8];
            longint py[8];
            pixel_write_t w;
            int k;
            cx = longint'(ctr_x);
            cy = longint'(ctr_y);
            u  = longint'(step_u);
            v  = longint'(step_v);
            wd = clamp_dim(width_reg);
            ht = clamp_dim(height_reg);
            px = '{cx + u, cx - u, cx + u, cx - u, cx + v, cx - v, cx + v, cx - v};
            py = '{cy + v, cy + v, cy - v, cy - v, cy + u, cy + u, cy - u, cy - u};
            for (k = 0; k < 8; k++)
            begin
                xs = place(px[k], scroll_x_reg);
                ys = place(py[k], scroll_y_reg);
                a  = xs + ys * wd;
                w  = '0;
                if (xs >= 0 && xs < wd && ys >= 0 && ys < ht)
                begin
                    w.x    = xs[PIX_W-1:0];
                    w.y    = ys[PIX_W-1:0];
                    w.addr = a[ADDR_W-1:0];
                    w.we   = 1'b1;
                end
                w.color = held_color;
                w.last  = (k == 7);
                w.done  = done;
                pending_pixels.push_back(w);
            end
        endfunction

        // Advance the circle state for one accepted item and queue its points
        function void note_item(circle_item_t it);
            longint x;
            longint y;
            longint r;
            longint sx;
            longint sy;
            logic done;
            if (it.op == OP_START)
            begin
                starts++;
                x  = longint'(it.cx);
                y  = longint'(it.cy);
                r  = longint'(it.radius);
                sx = longint'(scroll_x_reg);
                sy = longint'(scroll_y_reg);
                // Cull on the raw registers, scroll applied even when locked
                if ((x + r) * FRAC_SCALE + sx < 0 ||
                    (x - r) * FRAC_SCALE + sx > longint'(width_reg) * FRAC_SCALE ||
                    (y + r) * FRAC_SCALE + sy < 0 ||
                    (y - r) * FRAC_SCALE + sy > longint'(height_reg) * FRAC_SCALE)
                begin
                    culled++;
                    running = 1'b0;
                    push_null();
                    return;
                end
                ctr_x      = it.cx;
                ctr_y      = it.cy;
                step_u     = '0;
                step_v     = STEP_W'(r);
                dterm      = DEC_W'(3 - 2 * r);
                held_color = it.color;
                held_lock  = it.lock;
                running    = 1'b1;
                push_octants(1'b0);
            end
            else
            begin
                steps++;
                if (!running)
                begin
                    idle_steps++;
                    push_null();
                    return;
                end
                step_u = STEP_W'(step_u + 1);
                if (dterm > 0)
                begin
                    step_v = STEP_W'(step_v - 1);
                    dterm  = DEC_W'(dterm + 4 * (step_u - step_v) + 10);
                end
                else
                    dterm = DEC_W'(dterm + 4 * step_u + 6);
                done = (step_v < step_u);
                if (done)
                begin
                    running = 1'b0;
                    finished++;
                end
                push_octants(done);
            end
        endfunction

        function void check_field(string field, longint unsigned want, longint unsigned got);
            if (want != got)
            begin
                errors++;
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            end
        endfunction

        // Compare one accepted pixel against the oldest expected one
        function void check_pixel(pixel_write_t got);
            pixel_write_t want;
            checked++;
            if (got.we)
                on_screen++;
            if (pending_pixels.size() == 0)
            begin
                errors++;
                $error("pixel_write: none expected, got x %0d y %0d addr %0d we %0d",
                       got.x, got.y, got.addr, got.we);
                return;
            end
            want = pending_pixels.pop_front();
            check_field("pixel_x", want.x, got.x);
            check_field("pixel_y", want.y, got.y);
            check_field("pixel_addr", want.addr, got.addr);
            check_field("pixel_color", want.color, got.color);
            check_field("write_enable", want.we, got.we);
            check_field("last_of_step", want.last, got.last);
            check_field("circle_done", want.done, got.done);
        endfunction
    endclass

endpackage

[tb/testbench.sv]
`timescale 1ns / 1ps
// Top-level bench for midpoint_circle_rasterizer_unit: drives circles and steps,
// writes registers between phases. Depends on mcr_pkg and pixel_scoreboard_pkg.
module testbench;
    import mcr_pkg::*;
    import pixel_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT      = 400000;
    localparam int DRAIN_CYCLES     = 16;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int MAX_WALK         = 60;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_wr_en;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic                      op;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic [RADIUS_W-1:0]       circle_radius;
    logic [COLOR_W-1:0]        pen_color;
    logic                      lock_to_screen;
    logic                      out_valid;
    logic                      out_stall;
    logic [PIX_W-1:0]          pixel_x;
    logic [PIX_W-1:0]          pixel_y;
    logic [ADDR_W-1:0]         pixel_addr;
    logic [COLOR_W-1:0]        pixel_color;
    logic                      write_enable;
    logic                      last_of_step;
    logic                      circle_done;

    pixel_scoreboard sb;
    int unsigned     send_idle_pct  = 0;
    int unsigned     recv_stall_pct = 0;
    logic            hold_req       = 1'b0;
    int              hold_left      = 0;
    int              items_sent     = 0;
    int              settings_used  = 1;
    int              cycle_count    = 0;

    midpoint_circle_rasterizer_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .center_x       (center_x),
        .center_y       (center_y),
        .circle_radius  (circle_radius),
        .pen_color      (pen_color),
        .lock_to_screen (lock_to_screen),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pixel_x        (pixel_x),
        .pixel_y        (pixel_y),
        .pixel_addr     (pixel_addr),
        .pixel_color    (pixel_color),
        .write_enable   (write_enable),
        .last_of_step   (last_of_step),
        .circle_done    (circle_done)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Check every accepted pixel
    always @(posedge clk)
    begin : pixel_monitor
        pixel_write_t got;
        if (out_valid && !out_stall)
        begin
            got.x     = pixel_x;
            got.y     = pixel_y;
            got.addr  = pixel_addr;
            got.color = pixel_color;
            got.we    = write_enable;
            got.last  = last_of_step;
            got.done  = circle_done;
            sb.check_pixel(got);
        end
    end

    // Output stall: random per cycle, or one long hold when requested
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = LONG_HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Offer one item after random idle cycles; enter and leave at a falling edge
    task automatic send_item(circle_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        op             <= it.op;
        center_x       <= it.cx;
        center_y       <= it.cy;
        circle_radius  <= it.radius;
        pen_color      <= it.color;
        lock_to_screen <= it.lock;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_item(it);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // Hold until every expected pixel has arrived, then let the pipe settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Step item with every payload bit random; the block ignores the payload
    function automatic circle_item_t random_step();
        circle_item_t it;
        it.op     = OP_STEP;
        it.cx     = COORD_W'($urandom);
        it.cy     = COORD_W'($urandom);
        it.radius = RADIUS_W'($urandom);
        it.color  = COLOR_W'($urandom);
        it.lock   = 1'($urandom);
        return it;
    endfunction

    function automatic circle_item_t start_item(int cx, int cy, int r, logic [31:0] color,
                                                logic lock);
        circle_item_t it;
        it.op     = OP_START;
        it.cx     = cx[COORD_W-1:0];
        it.cy     = cy[COORD_W-1:0];
        it.radius = r[RADIUS_W-1:0];
        it.color  = color;
        it.lock   = lock;
        return it;
    endfunction

    // Start item mostly placed so the circle overlaps the visible window
    function automatic circle_item_t random_start();
        circle_item_t it;
        longint r;
        longint span_x;
        longint span_y;
        longint tx;
        longint ty;
        int unsigned sel;
        it    = random_step();
        it.op = OP_START;
        sel   = $urandom_range(0, 99);
        if (sel < 70)
            r = $urandom_range(0, 24);
        else if (sel < 95)
            r = $urandom_range(25, 200);
        else
            r = $urandom_range(201, 4095);
        it.radius = r[RADIUS_W-1:0];
        if ($urandom_range(0, 9) != 0)
        begin
            span_x = sb.clamp_dim(sb.width_reg) + 2 * r + 8;
            span_y = sb.clamp_dim(sb.height_reg) + 2 * r + 8;
            tx     = longint'($urandom_range(0, 32'(span_x))) - r - 4
                     - longint'(sb.scroll_x_reg) / FRAC_SCALE;
            ty     = longint'($urandom_range(0, 32'(span_y))) - r - 4
                     - longint'(sb.scroll_y_reg) / FRAC_SCALE;
            it.cx  = tx[COORD_W-1:0];
            it.cy  = ty[COORD_W-1:0];
        end
        return it;
    endfunction

    task automatic walk_to_end();
        while (sb.running)
            send_item(random_step());
    endtask

    // Mostly whole circles with random content, some cut short, some noise
    task automatic gen_traffic(int n);
        int sent;
        int walk;
        circle_item_t it;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                send_item(random_start());
                sent++;
                walk = 0;
                while (sb.running && sent < n && walk < MAX_WALK && $urandom_range(0, 49) != 0)
                begin
                    send_item(random_step());
                    sent++;
                    walk++;
                end
            end
            else
            begin
                // stray step, or a start with raw random fields
                it = random_step();
                if ($urandom_range(0, 1) == 1)
                    it.op = OP_START;
                send_item(it);
                sent++;
            end
        end
    endtask

    task automatic run_phase(int wd, int ht, int sx, int sy, int unsigned send_pct,
                             int unsigned recv_pct, int n, logic long_hold);
        wait_idle();
        write_reg(CFG_SCREEN_WIDTH, wd[CFG_DATA_W-1:0]);
        write_reg(CFG_SCREEN_HEIGHT, ht[CFG_DATA_W-1:0]);
        write_reg(CFG_SCROLL_X, sx[CFG_DATA_W-1:0]);
        write_reg(CFG_SCROLL_Y, sy[CFG_DATA_W-1:0]);
        settings_used++;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        if (long_hold)
            hold_req = 1'b1;
        gen_traffic(n);
    endtask

    initial
    begin
        int unsigned mode_send[4];
        int unsigned mode_recv[4];
        int i;
        mode_send = '{0, 78, 0, 20};
        mode_recv = '{0, 0, 78, 20};
        sb             = new();
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        op             = OP_START;
        center_x       = '0;
        center_y       = '0;
        circle_radius  = '0;
        pen_color      = '0;
        lock_to_screen = 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed items on the reset register values
        send_item(random_step());
        send_item(start_item(0, 0, 0, 32'h0, 1'b0));
        walk_to_end();
        send_item(random_step());
        send_item(start_item(32767, -32768, 4095, 32'hFFFF_FFFF, 1'b1));
        send_item(start_item(-32768, 32767, 0, 32'hFFFF_FFFF, 1'b0));
        // cull boundaries on both sides of each axis
        send_item(start_item(-3, 10, 3, 32'hA5A5_5A5A, 1'b0));
        send_item(start_item(643, 10, 3, 32'h5A5A_A5A5, 1'b1));
        send_item(start_item(644, 10, 3, 32'h0F0F_F0F0, 1'b0));
        send_item(start_item(10, -4, 3, 32'hF0F0_0F0F, 1'b0));
        send_item(start_item(10, 484, 3, 32'h1111_1111, 1'b0));
        // largest radius, cut short by a new circle
        send_item(start_item(320, 240, 4095, 32'hFFFF_FFFF, 1'b1));
        repeat (3) send_item(random_step());
        send_item(start_item(5, 5, 10, 32'h1234_5678, 1'b0));
        walk_to_end();

        // Register extremes and idling modes
        run_phase(4096, 4096, 0, 0, 0, 0, 60, 1'b0);
        run_phase(1, 1, -524288, 524287, 78, 0, 50, 1'b0);
        run_phase(8191, 0, 37, -21, 0, 78, 50, 1'b0);
        run_phase(640, 480, $urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
                  20, 20, 80, 1'b1);
        run_phase(4097, 13, -1, 15, 0, 0, 50, 1'b0);
        for (i = 0; i < 4; i++)
            run_phase($urandom_range(1, 800), $urandom_range(1, 600),
                      $urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
                      mode_send[i], mode_recv[i], 30, 1'b0);

        wait_idle();
        $display("Items %0d: %0d starts (%0d culled), %0d steps (%0d idle), %0d circles finished.",
                 items_sent, sb.starts, sb.culled, sb.steps, sb.idle_steps, sb.finished);
        $display("Checked %0d pixels (%0d on screen) over %0d register settings, %0d mismatches.",
                 sb.checked, sb.on_screen, settings_used, sb.errors);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[sim.f]
design/mcr_pkg.sv
design/mcr_front.sv
design/mcr_queue.sv
design/mcr_back.sv
design/midpoint_circle_rasterizer_unit.sv
tb/pixel_scoreboard_pkg.sv
tb/testbench.sv
